// ----- rtl/spcd_pkg.sv -----
// Shared types and constants of the spectrum peak column decimator.
package spcd_pkg;

   localparam int MAX_BINS  = 4096;
   localparam int LEVEL_W   = 16;
   localparam int IDX_W     = 12;
   localparam int CNT_W     = 13;
   localparam int XY_W      = 17;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;
   localparam int DIV_NUM_W = 35;
   localparam int DIV_DEN_W = 18;
   localparam int DIV_CNT_W = 6;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BIN_COUNT  = 3'd0,
      CSR_WIDTH_PX   = 3'd1,
      CSR_HEIGHT_PX  = 3'd2,
      CSR_ORIGIN_X   = 3'd3,
      CSR_ORIGIN_Y   = 3'd4,
      CSR_FLOOR_DB   = 3'd5,
      CSR_CEILING_DB = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_EVAL,
      S_DIVX,
      S_DIVY,
      S_LOAD
   } state_type;

   typedef struct packed {
      logic capture;
      logic mul;
      logic advance;
      logic div_start;
      logic div_sel_y;
      logic take_x;
      logic take_y;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic ends;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

// ----- rtl/spcd_if.sv -----
// Stream interfaces of the bin input channel and the point result channel.
interface spcd_req_if;
   import spcd_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [LEVEL_W-1:0] bin_level;
   modport source (output valid, output bin_level, input ready);
   modport sink   (input valid, input bin_level, output ready);
endinterface

interface spcd_rsp_if;
   import spcd_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [IDX_W-1:0]          column;
   logic [XY_W-1:0]           point_x;
   logic [XY_W-1:0]           point_y;
   logic signed [LEVEL_W-1:0] column_peak;
   logic                      frame_end;
   modport source (output valid, output column, output point_x, output point_y,
                   output column_peak, output frame_end, input ready);
   modport sink   (input valid, input column, input point_x, input point_y,
                   input column_peak, input frame_end, output ready);
endinterface

// ----- rtl/spectrum_peak_column_decimator_unit.sv -----
// Top level of the spectrum peak column decimator.
//
// Feed one spectrum bin level per beat on req_bus (valid/ready). Each frame
// of bin_count bins is folded into P = max(2, min(bin_count, width_px))
// display columns; neighboring columns share their boundary bin. A point
// beat on rsp_bus carries the column index, x and y in 1/16 pixel and the
// column peak; frame_end marks the last column.
// Settings are written on csr_we/csr_index/csr_data; write them only while
// the block is idle.
// A bin that does not close a column passes accept, multiply and bucket-end
// compare; a closing bin adds two passes of the shared bit-serial divider
// (x, then y) plus a load. A new bin waits until the last is through.
// The point appears in the output register in the cycle after the load.
// A stalled receiver holds the output register; the block keeps taking
// bins and only waits at the load of the next point.
// Reset: settings return to their defaults, the frame restarts at bin 0,
// column 0, and the output register empties.
module spectrum_peak_column_decimator_unit
   import spcd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   spcd_req_if.sink             req_bus,
   spcd_rsp_if.source           rsp_bus,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data
);

   cmd_type    cmd;
   status_type status;
   logic       ready;

   // Sequence each beat through multiply and compare, a closing beat also through divide and load.
   spcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (ready),
      .status    (status),
      .cmd       (cmd)
   );

   assign req_bus.ready = ready;

   spcd_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .bin_level (req_bus.bin_level),
      .cmd       (cmd),
      .status    (status),
      .rsp       (rsp_bus)
   );

endmodule

// ----- rtl/spcd_divider.sv -----
// Restoring radix-2 divider, one quotient bit per cycle.
module spcd_divider
   import spcd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_NUM_W-1:0] num,
   input  logic [DIV_DEN_W-1:0] den,
   output logic                 done,
   output logic [DIV_NUM_W-1:0] quot
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W:0]   rem_shift;
   logic [DIV_DEN_W:0]   rem_diff;

   assign rem_shift = {rem_ff, quo_ff[DIV_NUM_W-1]};
   assign rem_diff  = rem_shift - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_NUM_W - 1);
         den_in  = den;
         rem_in  = '0;
         quo_in  = num;
      end else if (busy_ff) begin
         if (rem_shift >= {1'b0, den_ff}) begin
            rem_in = rem_diff[DIV_DEN_W-1:0];
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[DIV_DEN_W-1:0];
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

// ----- rtl/spcd_datapath.sv -----
// Datapath: settings, frame counters, products, divider and result register.
module spcd_datapath
   import spcd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DAT_W-1:0]  csr_data,
   input  logic signed [LEVEL_W-1:0] bin_level,
   input  cmd_type               cmd,
   output status_type            status,
   spcd_rsp_if.source            rsp
);

   logic [CNT_W-1:0]          bin_count_ff, width_ff, height_ff;
   logic [IDX_W-1:0]          origin_x_ff, origin_y_ff;
   logic signed [LEVEL_W-1:0] floor_ff, ceil_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_count_ff <= CNT_W'(1024);
         width_ff     <= CNT_W'(1024);
         height_ff    <= CNT_W'(256);
         origin_x_ff  <= '0;
         origin_y_ff  <= '0;
         floor_ff     <= -16'sd15360;
         ceil_ff      <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_BIN_COUNT:  bin_count_ff <= csr_data[CNT_W-1:0];
            CSR_WIDTH_PX:   width_ff     <= csr_data[CNT_W-1:0];
            CSR_HEIGHT_PX:  height_ff    <= csr_data[CNT_W-1:0];
            CSR_ORIGIN_X:   origin_x_ff  <= csr_data[IDX_W-1:0];
            CSR_ORIGIN_Y:   origin_y_ff  <= csr_data[IDX_W-1:0];
            CSR_FLOOR_DB:   floor_ff     <= csr_data;
            CSR_CEILING_DB: ceil_ff      <= csr_data;
            default: ;
         endcase
      end
   end

   // Derived frame geometry.
   logic [CNT_W-1:0] nb, npw, np;
   logic [IDX_W-1:0] nbm1, npm1;
   logic [CNT_W-1:0] span2;

   always_comb begin
      if (bin_count_ff < CNT_W'(2))
         nb = CNT_W'(2);
      else if (bin_count_ff > CNT_W'(MAX_BINS))
         nb = CNT_W'(MAX_BINS);
      else
         nb = bin_count_ff;
      npw  = (width_ff < nb) ? width_ff : nb;
      np   = (npw < CNT_W'(2)) ? CNT_W'(2) : npw;
      nbm1 = IDX_W'(nb - CNT_W'(1));
      npm1 = IDX_W'(np - CNT_W'(1));
      span2 = {npm1, 1'b0};
   end

   // Frame state.
   logic [IDX_W-1:0]          bin_ff, col_ff;
   logic signed [LEVEL_W-1:0] run_ff, level_ff;

   logic signed [LEVEL_W-1:0] peak, p_clamp;
   logic                      range_ok, last_c;
   logic [IDX_W-1:0]          c_eff;
   logic [LEVEL_W:0]          diff17, d17;
   logic [CNT_W-1:0]          binp1;

   always_comb begin
      peak     = (level_ff > run_ff) ? level_ff : run_ff;
      range_ok = ceil_ff > floor_ff;
      if (peak < floor_ff)
         p_clamp = floor_ff;
      else if (peak > ceil_ff)
         p_clamp = ceil_ff;
      else
         p_clamp = peak;
      diff17 = {ceil_ff[LEVEL_W-1], ceil_ff} - {p_clamp[LEVEL_W-1], p_clamp};
      d17    = {ceil_ff[LEVEL_W-1], ceil_ff} - {floor_ff[LEVEL_W-1], floor_ff};
      last_c = col_ff >= npm1;
      c_eff  = last_c ? npm1 : col_ff;
      binp1  = {1'b0, bin_ff} + CNT_W'(1);
   end

   logic [25:0]               prod_span_ff, prod_bnd_ff;
   logic [24:0]               prod_cw_ff;
   logic [28:0]               prod_hd_ff;
   logic                      last_ff, bin_end_ff;
   logic signed [LEVEL_W-1:0] peak_ff;
   logic [IDX_W-1:0]          c_eff_ff;

   // Hold products for the bucket-end test and the two numerators.
   always_ff @(posedge clock) begin
      if (cmd.capture)
         level_ff <= bin_level;
      if (cmd.mul) begin
         prod_span_ff <= 26'(span2) * 26'(binp1);
         prod_bnd_ff  <= 26'({col_ff, 1'b1}) * 26'(nbm1);
         prod_cw_ff   <= 25'(c_eff) * 25'(width_ff);
         prod_hd_ff   <= 29'(height_ff) * 29'(diff17[LEVEL_W-1:0]);
         last_ff      <= last_c;
         bin_end_ff   <= bin_ff >= nbm1;
         peak_ff      <= peak;
         c_eff_ff     <= c_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_ff <= '0;
         col_ff <= '0;
         run_ff <= {1'b1, {(LEVEL_W-1){1'b0}}};
      end else if (cmd.advance) begin
         run_ff <= peak_ff;
         bin_ff <= bin_ff + IDX_W'(1);
      end else if (cmd.load) begin
         if (last_ff) begin
            bin_ff <= '0;
            col_ff <= '0;
            run_ff <= {1'b1, {(LEVEL_W-1){1'b0}}};
         end else begin
            run_ff <= level_ff;
            col_ff <= col_ff + IDX_W'(1);
            bin_ff <= bin_ff + IDX_W'(1);
         end
      end
   end

   // Shared divider for both coordinates.
   logic [DIV_NUM_W-1:0] div_num, div_quot;
   logic [DIV_DEN_W-1:0] div_den;
   logic                 div_done;

   always_comb begin
      if (cmd.div_sel_y) begin
         div_num = DIV_NUM_W'({prod_hd_ff, 5'b0}) + DIV_NUM_W'(d17[LEVEL_W-1:0]);
         div_den = DIV_DEN_W'({d17[LEVEL_W-1:0], 1'b0});
      end else begin
         div_num = DIV_NUM_W'({prod_cw_ff, 5'b0}) + DIV_NUM_W'(npm1);
         div_den = DIV_DEN_W'(span2);
      end
   end

   spcd_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   logic [DIV_DEN_W-1:0] qx_ff, qy_ff;

   always_ff @(posedge clock) begin
      if (cmd.take_x)
         qx_ff <= div_quot[DIV_DEN_W-1:0];
      if (cmd.take_y)
         qy_ff <= div_quot[DIV_DEN_W-1:0];
   end

   // Offset and saturate coordinates.
   logic [XY_W+1:0] x_sum, y_sum;
   logic [XY_W-1:0] x_sat, y_sat;

   always_comb begin
      x_sum = (XY_W+2)'({origin_x_ff, 4'b0}) + (XY_W+2)'(qx_ff);
      if (range_ok)
         y_sum = (XY_W+2)'({origin_y_ff, 4'b0}) + (XY_W+2)'(qy_ff);
      else
         y_sum = (XY_W+2)'({origin_y_ff, 4'b0}) + (XY_W+2)'({height_ff, 4'b0});
      x_sat = (x_sum > (XY_W+2)'({XY_W{1'b1}})) ? {XY_W{1'b1}} : x_sum[XY_W-1:0];
      y_sat = (y_sum > (XY_W+2)'({XY_W{1'b1}})) ? {XY_W{1'b1}} : y_sum[XY_W-1:0];
   end

   logic                      rsp_valid_ff;
   logic [IDX_W-1:0]          rsp_col_ff;
   logic [XY_W-1:0]           rsp_x_ff, rsp_y_ff;
   logic signed [LEVEL_W-1:0] rsp_peak_ff;
   logic                      rsp_end_ff;

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (cmd.load)
         rsp_valid_ff <= 1'b1;
      else if (rsp.ready)
         rsp_valid_ff <= 1'b0;
      if (cmd.load) begin
         rsp_col_ff  <= c_eff_ff;
         rsp_x_ff    <= x_sat;
         rsp_y_ff    <= y_sat;
         rsp_peak_ff <= peak_ff;
         rsp_end_ff  <= last_ff;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.column      = rsp_col_ff;
   assign rsp.point_x     = rsp_x_ff;
   assign rsp.point_y     = rsp_y_ff;
   assign rsp.column_peak = rsp_peak_ff;
   assign rsp.frame_end   = rsp_end_ff;

   assign status.ends     = last_ff ? bin_end_ff : (prod_span_ff > prod_bnd_ff);
   assign status.div_done = div_done;
   assign status.out_free = !rsp_valid_ff || rsp.ready;

endmodule

// ----- rtl/spcd_ctrl.sv -----
// Controller state machine sequencing one bin through the datapath.
module spcd_ctrl
   import spcd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= S_IDLE;
      else
         state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (status.ends) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIVX;
            end else begin
               cmd.advance = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_DIVX: begin
            if (status.div_done) begin
               cmd.take_x    = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_sel_y = 1'b1;
               state_in      = S_DIVY;
            end
         end
         S_DIVY: begin
            cmd.div_sel_y = 1'b1;
            if (status.div_done) begin
               cmd.take_y = 1'b1;
               state_in   = S_LOAD;
            end
         end
         S_LOAD: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> status.out_free)
      else $error("result loaded over a pending beat");
   a_accept_mul: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_MUL))
      else $error("accepted beat not sent to the multiply step");
   a_take_done: assert property (@(posedge clock) disable iff (reset)
      (cmd.take_x || cmd.take_y) |-> status.div_done)
      else $error("quotient taken before divider finished");
`endif

endmodule
